// ----- rtl/ir_pulse_command_decoder_defines.svh -----
// Assertion macros shared by the decoder's checker.
`ifndef IR_PULSE_COMMAND_DECODER_DEFINES_SVH
`define IR_PULSE_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define IRCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define IRCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ircd_pkg.sv -----
// Types, constants and helper functions of the IR pulse command decoder.
package ircd_pkg;

	localparam int NUM_CODES = 5;
	localparam int IDX_W     = 4;
	localparam int DATA_W    = 32;
	localparam int LEN_W     = 16;
	localparam int WORD_W    = 32;
	localparam int CMD_W     = 3;

	// Longest pulse still counted as a logic one.
	localparam logic [LEN_W-1:0] ONE_LIMIT = 16'd10000;

	localparam logic [LEN_W-1:0] LOGIC1_MIN_RST = 16'd1200;
	localparam logic [LEN_W-1:0] LOGIC0_MIN_RST = 16'd300;
	localparam logic [LEN_W-1:0] LOGIC0_MAX_RST = 16'd900;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_LOGIC1_MIN      = 4'd0;
	localparam logic [IDX_W-1:0] REG_LOGIC0_MIN      = 4'd1;
	localparam logic [IDX_W-1:0] REG_LOGIC0_MAX      = 4'd2;
	localparam logic [IDX_W-1:0] REG_CODE_REVERSE    = 4'd3;
	localparam logic [IDX_W-1:0] REG_CODE_FORWARD    = 4'd4;
	localparam logic [IDX_W-1:0] REG_CODE_TURN_RIGHT = 4'd5;
	localparam logic [IDX_W-1:0] REG_CODE_TURN_LEFT  = 4'd6;
	localparam logic [IDX_W-1:0] REG_CODE_STOP       = 4'd7;

	// Slots of the code table, in test order.
	localparam int SLOT_REVERSE    = 0;
	localparam int SLOT_FORWARD    = 1;
	localparam int SLOT_TURN_RIGHT = 2;
	localparam int SLOT_TURN_LEFT  = 3;
	localparam int SLOT_STOP       = 4;

	// Command codes reported on the response.
	localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FORWARD    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TURN_RIGHT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TURN_LEFT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_STOP       = 3'd5;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_ON,
		MODE_REV
	} mode_t;

	typedef struct packed {
		logic             kind;
		logic [LEN_W-1:0] pulse_length;
	} req_t;

	typedef struct packed {
		logic             left_enable;
		logic             left_reverse;
		logic             right_enable;
		logic             right_reverse;
		logic [CMD_W-1:0] command;
	} rsp_t;

	typedef struct packed {
		logic on;
		logic back;
	} motor_t;

	typedef logic [NUM_CODES-1:0][WORD_W-1:0] code_set_t;

	localparam mode_t LEFT_MODES [NUM_CODES] =
		'{MODE_REV, MODE_ON, MODE_ON, MODE_REV, MODE_OFF};
	localparam mode_t RIGHT_MODES [NUM_CODES] =
		'{MODE_REV, MODE_ON, MODE_REV, MODE_ON, MODE_OFF};

	// Off keeps the direction; on and reverse set both pins.
	function automatic motor_t apply_mode(input mode_t mode, input motor_t cur);
		motor_t nxt;
		nxt = cur;
		unique case (mode)
			MODE_OFF: nxt.on = 1'b0;
			MODE_ON: begin
				nxt.on   = 1'b1;
				nxt.back = 1'b0;
			end
			MODE_REV: begin
				nxt.on   = 1'b1;
				nxt.back = 1'b1;
			end
			default: nxt = cur;
		endcase
		return nxt;
	endfunction

endpackage

// ----- rtl/ircd_match.sv -----
// Code table match: tests the bit word against the five command codes in order.
module ircd_match (
	input  logic [ircd_pkg::WORD_W-1:0] word,
	input  ircd_pkg::code_set_t         codes,
	input  ircd_pkg::motor_t            left,
	input  ircd_pkg::motor_t            right,
	output logic [ircd_pkg::WORD_W-1:0] word_nxt,
	output ircd_pkg::motor_t            left_nxt,
	output ircd_pkg::motor_t            right_nxt,
	output logic [ircd_pkg::CMD_W-1:0]  command
);
	import ircd_pkg::*;

	// Each test sees the word left by the one before; a hit clears it, so a
	// later zero code hits as well.
	always_comb begin
		logic [WORD_W-1:0] w;
		motor_t            l;
		motor_t            r;
		logic [CMD_W-1:0]  c;
		w = word;
		l = left;
		r = right;
		c = CMD_NONE;
		for (int i = 0; i < NUM_CODES; i++) begin
			if (w == codes[i]) begin
				l = apply_mode(LEFT_MODES[i], l);
				r = apply_mode(RIGHT_MODES[i], r);
				w = '0;
				c = CMD_W'(i + 1);
			end
		end
		word_nxt  = w;
		left_nxt  = l;
		right_nxt = r;
		command   = c;
	end

endmodule

// ----- rtl/ir_pulse_command_decoder.sv -----
// IR pulse command decoder: pulse lengths to bit word, timeouts to motor commands.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_ready  | kind, pulse_length
//   rsp     | out       | rsp_valid/rsp_ready  | motor pins and command code
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index (4 b), cfg_data (32 b)
//
// One request per cycle sustained while rsp_ready is high; a taken request goes to the input register first.
// The input register feeds one level of compare/shift logic into the response register.
// A stalled response holds the input stage; req_ready drops only when both are full.
// Reset clears the bit word, the motor state and the valid flags and loads the
// register defaults; cfg_ready is always high.
module ir_pulse_command_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ircd_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output ircd_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ircd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [ircd_pkg::DATA_W-1:0] cfg_data
);
	import ircd_pkg::*;

	// Configuration registers.
	logic [LEN_W-1:0] logic1_min_q;
	logic [LEN_W-1:0] logic0_min_q;
	logic [LEN_W-1:0] logic0_max_q;
	code_set_t        codes_q;

	// Input stage.
	logic valid_s1;
	req_t req_s1;

	// Decoder state.
	logic [WORD_W-1:0] word_q;
	motor_t            left_q;
	motor_t            right_q;

	// Response register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Next-state logic.
	logic              advance;
	logic              one_hit;
	logic              zero_hit;
	logic [WORD_W-1:0] word_one;
	logic [WORD_W-1:0] word_pulse;
	logic [WORD_W-1:0] word_match;
	motor_t            left_match;
	motor_t            right_match;
	logic [CMD_W-1:0]  cmd_match;
	logic [WORD_W-1:0] word_nxt;
	motor_t            left_nxt;
	motor_t            right_nxt;
	logic [CMD_W-1:0]  cmd_nxt;

	assign cfg_ready = 1'b1;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logic1_min_q <= LOGIC1_MIN_RST;
			logic0_min_q <= LOGIC0_MIN_RST;
			logic0_max_q <= LOGIC0_MAX_RST;
			codes_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOGIC1_MIN:      logic1_min_q <= cfg_data[LEN_W-1:0];
				REG_LOGIC0_MIN:      logic0_min_q <= cfg_data[LEN_W-1:0];
				REG_LOGIC0_MAX:      logic0_max_q <= cfg_data[LEN_W-1:0];
				REG_CODE_REVERSE:    codes_q[SLOT_REVERSE]    <= cfg_data;
				REG_CODE_FORWARD:    codes_q[SLOT_FORWARD]    <= cfg_data;
				REG_CODE_TURN_RIGHT: codes_q[SLOT_TURN_RIGHT] <= cfg_data;
				REG_CODE_TURN_LEFT:  codes_q[SLOT_TURN_LEFT]  <= cfg_data;
				REG_CODE_STOP:       codes_q[SLOT_STOP]       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input stage whenever the response register is free or drains.
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Pulse request: a one first, then a zero, each from its own range.
	assign one_hit  = (req_s1.pulse_length <= ONE_LIMIT) &&
		(req_s1.pulse_length >= logic1_min_q);
	assign zero_hit = (req_s1.pulse_length <= logic0_max_q) &&
		(req_s1.pulse_length >= logic0_min_q);
	assign word_one   = one_hit ? {word_q[WORD_W-2:0], 1'b1} : word_q;
	assign word_pulse = zero_hit ? {word_one[WORD_W-2:0], 1'b0} : word_one;

	// Timeout request: run the code table.
	ircd_match u_match (
		.word      (word_q),
		.codes     (codes_q),
		.left      (left_q),
		.right     (right_q),
		.word_nxt  (word_match),
		.left_nxt  (left_match),
		.right_nxt (right_match),
		.command   (cmd_match)
	);

	always_comb begin
		if (req_s1.kind) begin
			word_nxt  = word_match;
			left_nxt  = left_match;
			right_nxt = right_match;
			cmd_nxt   = cmd_match;
		end else begin
			word_nxt  = word_pulse;
			left_nxt  = left_q;
			right_nxt = right_q;
			cmd_nxt   = CMD_NONE;
		end
	end

	// Commit the state together with the response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			left_q      <= '0;
			right_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				word_q  <= word_nxt;
				left_q  <= left_nxt;
				right_q <= right_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.left_enable   <= left_nxt.on;
			rsp_q.left_reverse  <= left_nxt.back;
			rsp_q.right_enable  <= right_nxt.on;
			rsp_q.right_reverse <= right_nxt.back;
			rsp_q.command       <= cmd_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/ircd_checker.sv -----
// Port-level checker for the IR pulse command decoder, bound to the top level.
`include "ir_pulse_command_decoder_defines.svh"

module ircd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ircd_pkg::rsp_t rsp
);
	import ircd_pkg::*;

	`IRCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")
	`IRCD_ASSERT_NOW(a_stop_off, rsp_valid && rsp.command == CMD_STOP, !rsp.left_enable && !rsp.right_enable, "stop left a motor enabled")
	`IRCD_ASSERT_NOW(a_reverse_pins, rsp_valid && rsp.command == CMD_REVERSE, rsp.left_enable && rsp.left_reverse && rsp.right_enable && rsp.right_reverse, "reverse pins wrong")
	`IRCD_ASSERT_NOW(a_right_pins, rsp_valid && rsp.command == CMD_TURN_RIGHT, rsp.left_enable && !rsp.left_reverse && rsp.right_enable && rsp.right_reverse, "turn right pins wrong")

endmodule

bind ir_pulse_command_decoder ircd_checker u_ircd_checker (.*);
